[sv/iso_datetime_field_parser_assert.svh]
// ----------------------------------------------------------------------------
// iso date-time field parser assertion macros
// shared property forms for the parser modules, clocked on clk, off in reset
// ----------------------------------------------------------------------------
`ifndef ISO_DATETIME_FIELD_PARSER_ASSERT_SVH
`define ISO_DATETIME_FIELD_PARSER_ASSERT_SVH

// same-cycle implication
`define IDTP_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IDTP_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/idtp_pkg.sv]
// ----------------------------------------------------------------------------
// idtp_pkg
// types, character codes and per-character helpers of the date-time parser
// ----------------------------------------------------------------------------
package idtp_pkg;

    localparam int FIELD_W        = 32;
    localparam int NFIELDS        = 6;
    localparam int PREFIX_MAX_DEF = 16;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_T     = 8'h54;

    localparam logic [FIELD_W-1:0] MAG_LIMIT = 32'h8000_0000;
    localparam logic [FIELD_W-1:0] POS_MAX   = 32'h7FFF_FFFF;
    localparam logic [FIELD_W-1:0] MONTH_MAX = 32'd12;
    localparam logic [FIELD_W-1:0] DAY_MAX   = 32'd31;
    localparam logic [FIELD_W-1:0] DIG_RADIX = 32'd10;

    typedef enum logic [2:0] {
        PH_YEAR,
        PH_MONTH,
        PH_DAY,
        PH_HOUR,
        PH_MINUTE,
        PH_SECOND,
        PH_DONE
    } phase_t;

    // class of the first held prefix character
    typedef enum logic [1:0] {
        CLS_SPACE,
        CLS_MINUS,
        CLS_OTHER
    } cls_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] year;
        logic signed [FIELD_W-1:0] month;
        logic signed [FIELD_W-1:0] day;
        logic signed [FIELD_W-1:0] hour;
        logic signed [FIELD_W-1:0] minute;
        logic signed [FIELD_W-1:0] second;
        logic                      date_ok;
    } res_t;

    function automatic logic is_ws(logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_sign(logic [7:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS);
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic cls_t char_cls(logic [7:0] c);
        cls_t k;
        priority if (c == CH_SPACE) k = CLS_SPACE;
        else if (c == CH_MINUS)     k = CLS_MINUS;
        else                        k = CLS_OTHER;
        return k;
    endfunction

    // separator test after a field
    function automatic phase_t sep_next(phase_t f, logic [7:0] c);
        phase_t p;
        priority if (f <= PH_MONTH && c == CH_MINUS)
            p = phase_t'(f + 3'd1);
        else if (f <= PH_DAY && (c == CH_T || c == CH_SPACE))
            p = PH_HOUR;
        else if ((f == PH_HOUR || f == PH_MINUTE) && c == CH_COLON)
            p = phase_t'(f + 3'd1);
        else
            p = PH_DONE;
        return p;
    endfunction

    // separator test on the first held prefix character
    function automatic phase_t first_next(phase_t f, cls_t k);
        phase_t p;
        priority if (k == CLS_SPACE && f <= PH_DAY)
            p = PH_HOUR;
        else if (k == CLS_MINUS && f <= PH_MONTH)
            p = phase_t'(f + 3'd1);
        else
            p = PH_DONE;
        return p;
    endfunction

    // acc * 10 + digit, clamped at 2^31
    function automatic logic [FIELD_W-1:0] sat_mac(logic [FIELD_W-1:0] acc, logic [7:0] c);
        logic [FIELD_W+3:0] t;
        t = (FIELD_W+4)'({acc, 3'b000}) + (FIELD_W+4)'({acc, 1'b0})
          + (FIELD_W+4)'(c - CH_ZERO);
        return (t > (FIELD_W+4)'(MAG_LIMIT)) ? MAG_LIMIT : t[FIELD_W-1:0];
    endfunction

    function automatic logic [FIELD_W-1:0] field_value(logic [FIELD_W-1:0] acc, logic neg);
        logic [FIELD_W-1:0] v;
        if (neg)
            v = '0 - acc;
        else
            v = acc[FIELD_W-1] ? POS_MAX : acc;
        return v;
    endfunction

endpackage

[sv/idtp_scan.sv]
// ----------------------------------------------------------------------------
// idtp_scan
// per-character field scanner: parse state, field store and end-of-string result
// ----------------------------------------------------------------------------
`include "iso_datetime_field_parser_assert.svh"

module idtp_scan #(
    parameter int PREFIX_MAX = idtp_pkg::PREFIX_MAX_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        ch,
    output logic              res_vld,
    output idtp_pkg::res_t    res
);

    localparam int              PW       = $clog2(PREFIX_MAX + 1);
    localparam logic [PW-1:0]   PCNT_MAX = PW'(PREFIX_MAX);
    localparam int              IW       = $clog2(idtp_pkg::NFIELDS);

    // the held prefix is whitespace then at most one sign; only its count,
    // the class of its first character and whether the sign was kept matter
    typedef struct packed {
        idtp_pkg::phase_t           phase;
        logic [idtp_pkg::FIELD_W-1:0] accum;
        logic                       neg;
        logic                       digits;
        logic                       sign;
        logic                       kept;
        idtp_pkg::cls_t             cls;
        logic [PW-1:0]              pcnt;
    } st_t;

    function automatic st_t fresh(idtp_pkg::phase_t p);
        st_t s;
        s.phase  = p;
        s.accum  = '0;
        s.neg    = 1'b0;
        s.digits = 1'b0;
        s.sign   = 1'b0;
        s.kept   = 1'b0;
        s.cls    = idtp_pkg::CLS_SPACE;
        s.pcnt   = '0;
        return s;
    endfunction

    st_t                          st_reg;
    st_t                          st_next;
    logic [idtp_pkg::FIELD_W-1:0] field_reg [idtp_pkg::NFIELDS];
    logic [idtp_pkg::FIELD_W-1:0] fin_val;
    logic [idtp_pkg::FIELD_W-1:0] fin_fields [idtp_pkg::NFIELDS];
    logic                         wr_en;
    logic                         ch_ws;
    logic                         ch_sign;
    logic                         ch_digit;
    logic                         room;
    idtp_pkg::cls_t               ch_cls;
    idtp_pkg::phase_t             hop;

    assign ch_ws    = idtp_pkg::is_ws(ch);
    assign ch_sign  = idtp_pkg::is_sign(ch);
    assign ch_digit = idtp_pkg::is_digit(ch);
    assign ch_cls   = idtp_pkg::char_cls(ch);
    assign room     = st_reg.pcnt < PCNT_MAX;
    assign fin_val  = idtp_pkg::field_value(st_reg.accum, st_reg.neg);
    assign hop      = idtp_pkg::first_next(st_reg.phase, st_reg.cls);

    always_comb
    begin
        st_next = st_reg;
        wr_en   = 1'b0;
        res_vld = 1'b0;
        if (step)
        begin
            if (ch == idtp_pkg::CH_NUL)
            begin
                res_vld = 1'b1;
                st_next = fresh(idtp_pkg::PH_YEAR);
            end
            else if (st_reg.phase != idtp_pkg::PH_DONE)
            begin
                if (!st_reg.digits && !st_reg.sign && ch_ws)
                begin
                    if (room)
                    begin
                        st_next.pcnt = st_reg.pcnt + 1'b1;
                        if (st_reg.pcnt == '0)
                            st_next.cls = ch_cls;
                    end
                end
                else if (!st_reg.digits && !st_reg.sign && ch_sign)
                begin
                    st_next.sign = 1'b1;
                    st_next.neg  = (ch == idtp_pkg::CH_MINUS);
                    if (room)
                    begin
                        st_next.pcnt = st_reg.pcnt + 1'b1;
                        st_next.kept = 1'b1;
                        if (st_reg.pcnt == '0)
                            st_next.cls = ch_cls;
                    end
                end
                else if (ch_digit)
                begin
                    st_next.accum  = idtp_pkg::sat_mac(st_reg.accum, ch);
                    st_next.digits = 1'b1;
                end
                else if (st_reg.digits)
                begin
                    // field ends: store it, test the separator
                    wr_en   = 1'b1;
                    st_next = fresh(idtp_pkg::sep_next(st_reg.phase, ch));
                end
                else if (st_reg.pcnt == '0)
                begin
                    st_next = fresh(idtp_pkg::sep_next(st_reg.phase, ch));
                end
                else if (hop == idtp_pkg::PH_DONE)
                begin
                    st_next.phase = idtp_pkg::PH_DONE;
                end
                else if (st_reg.cls == idtp_pkg::CLS_MINUS)
                begin
                    // lone minus opened the next field, then this character
                    st_next = fresh(hop);
                    if (ch_ws || ch_sign)
                    begin
                        st_next.pcnt = PW'(1);
                        st_next.cls  = ch_cls;
                        st_next.sign = ch_sign;
                        st_next.kept = ch_sign;
                        st_next.neg  = (ch == idtp_pkg::CH_MINUS);
                    end
                    else
                    begin
                        st_next = fresh(idtp_pkg::sep_next(hop, ch));
                    end
                end
                else
                begin
                    // leading space opened the hour, rest of prefix carried
                    if (!st_reg.kept && (ch_ws || ch_sign))
                    begin
                        st_next       = fresh(hop);
                        st_next.pcnt  = st_reg.pcnt;
                        st_next.cls   = st_reg.cls;
                        st_next.sign  = ch_sign;
                        st_next.kept  = ch_sign;
                        st_next.neg   = (ch == idtp_pkg::CH_MINUS);
                    end
                    else if (st_reg.pcnt == PW'(1))
                    begin
                        st_next = fresh(idtp_pkg::sep_next(hop, ch));
                    end
                    else
                    begin
                        st_next.phase = idtp_pkg::PH_DONE;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= fresh(idtp_pkg::PH_YEAR);
            for (int i = 0; i < idtp_pkg::NFIELDS; i++)
                field_reg[i] <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (res_vld)
            begin
                for (int i = 0; i < idtp_pkg::NFIELDS; i++)
                    field_reg[i] <= '0;
            end
            else if (wr_en)
            begin
                field_reg[IW'(st_reg.phase)] <= fin_val;
            end
        end
    end

    // the field still being read is folded in at end of string
    always_comb
    begin
        for (int i = 0; i < idtp_pkg::NFIELDS; i++)
            fin_fields[i] = (st_reg.digits && st_reg.phase == idtp_pkg::phase_t'(3'(i)))
                          ? fin_val : field_reg[i];
    end

    always_comb
    begin
        res.year    = fin_fields[0];
        res.month   = fin_fields[1];
        res.day     = fin_fields[2];
        res.hour    = fin_fields[3];
        res.minute  = fin_fields[4];
        res.second  = fin_fields[5];
        res.date_ok = (fin_fields[1] >= 32'd1) && (fin_fields[1] <= idtp_pkg::MONTH_MAX)
                   && (fin_fields[2] >= 32'd1) && (fin_fields[2] <= idtp_pkg::DAY_MAX);
    end

    `IDTP_CHECK_NEXT(a_restart, res_vld, st_reg.phase == idtp_pkg::PH_YEAR && st_reg.pcnt == '0, "scan state not restarted after end of string")
    `IDTP_CHECK(a_kept_sign, st_reg.kept, st_reg.sign && st_reg.pcnt != '0, "kept sign without sign or prefix")
    `IDTP_CHECK(a_pcnt_cap, st_reg.pcnt != '0, st_reg.pcnt <= PCNT_MAX, "prefix count past its cap")

endmodule

[sv/idtp_out_reg.sv]
// ----------------------------------------------------------------------------
// idtp_out_reg
// result register holding one finished string until its transfer
// ----------------------------------------------------------------------------
module idtp_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  idtp_pkg::res_t    res,
    input  logic              take,
    output logic              full,
    output logic              space,
    output idtp_pkg::res_t    data
);

    logic           vld_reg;
    logic           vld_next;
    idtp_pkg::res_t data_reg;

    assign space    = !vld_reg || take;
    assign vld_next = load || (vld_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= res;
    end

    assign full = vld_reg;
    assign data = data_reg;

endmodule

[sv/iso_datetime_field_parser.sv]
// ----------------------------------------------------------------------------
// iso_datetime_field_parser
// streaming date-time string parser: year-month-day, then hour:minute:second
// ----------------------------------------------------------------------------
//
//   channel   signals                              carries
//   -------   ----------------------------------   ---------------------------
//   char      char_valid / char_ready, ch          one character, zero ends it
//   result    result_valid / result_ready, year,   six fields and date check,
//             month, day, hour, minute, second,    one per string
//             date_ok
//
// one character is taken every cycle while char_ready is high; the scanner
// retires the character held in the input register each cycle unless stalled;
// a zero ends a string: input register, then scanner into result register
// reset clears the scan state, the field store and both valid flags
// char_ready drops only while a zero character sits in the input register and
// the result register still holds an earlier result that is not taken
// ----------------------------------------------------------------------------
`include "iso_datetime_field_parser_assert.svh"

module iso_datetime_field_parser #(
    parameter int PREFIX_MAX = idtp_pkg::PREFIX_MAX_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               char_valid,
    output logic               char_ready,
    input  logic [7:0]         ch,
    output logic               result_valid,
    input  logic               result_ready,
    output logic signed [31:0] year,
    output logic signed [31:0] month,
    output logic signed [31:0] day,
    output logic signed [31:0] hour,
    output logic signed [31:0] minute,
    output logic signed [31:0] second,
    output logic               date_ok
);

    // input register
    logic           in_vld_reg;
    logic           in_vld_next;
    logic [7:0]     ch_reg;

    // scanner and result register hookup
    logic           adv;
    logic           res_vld;
    logic           out_space;
    logic           out_full;
    idtp_pkg::res_t res;
    idtp_pkg::res_t out_data;

    // a held character moves on unless it ends a string that has nowhere to go
    assign adv        = in_vld_reg && ((ch_reg != idtp_pkg::CH_NUL) || out_space);
    assign char_ready = !in_vld_reg || adv;
    assign in_vld_next = char_ready ? char_valid : in_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= in_vld_next;
    end

    // payload loads on each char transfer
    always_ff @(posedge clk)
    begin
        if (char_valid && char_ready)
            ch_reg <= ch;
    end

    idtp_scan #(
        .PREFIX_MAX (PREFIX_MAX)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (adv),
        .ch      (ch_reg),
        .res_vld (res_vld),
        .res     (res)
    );

    idtp_out_reg u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (res_vld),
        .res   (res),
        .take  (result_ready),
        .full  (out_full),
        .space (out_space),
        .data  (out_data)
    );

    assign result_valid = out_full;
    assign year         = out_data.year;
    assign month        = out_data.month;
    assign day          = out_data.day;
    assign hour         = out_data.hour;
    assign minute       = out_data.minute;
    assign second       = out_data.second;
    assign date_ok      = out_data.date_ok;

    `IDTP_CHECK(a_load_has_room, res_vld, !out_full || result_ready, "result loaded over an untaken result")
    `IDTP_CHECK(a_stall_cause, !char_ready, in_vld_reg && ch_reg == idtp_pkg::CH_NUL && out_full && !result_ready, "char channel stalled without a blocked end of string")
    `IDTP_CHECK_NEXT(a_held_char, in_vld_reg && !adv, in_vld_reg && $stable(ch_reg), "held character lost while stalled")

endmodule
